### hw/rtl/blp_pkg.sv
// Shared types and constants of the breathing LED PWM block.
// Holds the register map, field widths and reset values.
// Has no dependencies; the counter, the top level and the checker use it.
package blp_pkg;

   // Widths of the fields and registers.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned LIMIT_W     = 16;
   localparam int unsigned STEP_W      = 16;
   localparam int unsigned LEVEL_W     = 4;
   localparam int unsigned SELECT_W    = 2;
   localparam int unsigned LED_COUNT   = 4;
   localparam int unsigned THRESH_W    = LEVEL_W + STEP_W;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PWM_PERIOD   = 3'd0,
      CSR_DUTY_STEP    = 3'd1,
      CSR_TOP_LEVEL    = 3'd2,
      CSR_DWELL_LENGTH = 3'd3,
      CSR_LED_SELECT   = 3'd4
   } csr_index_type;

   // Register values after reset.
   localparam logic [LIMIT_W-1:0]  PWM_PERIOD_RESET   = 16'd500;
   localparam logic [STEP_W-1:0]   DUTY_STEP_RESET    = 16'd50;
   localparam logic [LEVEL_W-1:0]  TOP_LEVEL_RESET    = 4'd10;
   localparam logic [LIMIT_W-1:0]  DWELL_LENGTH_RESET = 16'd100;
   localparam logic [SELECT_W-1:0] LED_SELECT_RESET   = 2'd3;

   // What a wrapping counter reports back for the current beat.
   typedef struct packed {
      logic ticked;
      logic wrapped;
   } count_status_type;

endpackage

### hw/rtl/breathing_led_pwm.sv
// Breathing LED PWM generator: top level with registers, ramp and result stage.
// Depends on blp_pkg and instantiates blp_wrap_counter twice.
//
//   channel   ports                             width of payload
//   req       req_valid/req_stall               fast_tick 1, slow_tick 1
//   rsp       rsp_valid/rsp_stall               led_mask 4, level_now 4, ramping_up 1
//   csr       csr_write/csr_index/csr_wdata     index 3, data 16
//
// One beat is accepted per cycle while req_stall is low; its result passes the state and result registers.
// The counters and the brightness ramp update at the accepting edge; the result
// stage then forms the threshold (one 4x16 product) and the LED compare.
// Synchronous reset returns settings and state, not the result, to power-up values.
// A stall on rsp holds the result; one further beat is absorbed, then req stalls.
module breathing_led_pwm #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_fast_tick,
   input  logic                                req_slow_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [blp_pkg::LED_COUNT-1:0]       rsp_led_mask,
   output logic [blp_pkg::LEVEL_W-1:0]         rsp_level_now,
   output logic                                rsp_ramping_up,
   input  logic                                csr_write,
   input  logic [blp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [blp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned CMP_W =
      (COUNT_WIDTH > blp_pkg::THRESH_W) ? COUNT_WIDTH : blp_pkg::THRESH_W;

   // Configuration registers.
   logic [blp_pkg::LIMIT_W-1:0]  pwm_period_ff;
   logic [blp_pkg::STEP_W-1:0]   duty_step_ff;
   logic [blp_pkg::LEVEL_W-1:0]  top_level_ff;
   logic [blp_pkg::LIMIT_W-1:0]  dwell_length_ff;
   logic [blp_pkg::SELECT_W-1:0] led_select_ff;

   // Handshake and stage control.
   logic req_accept;
   logic state_valid_ff, state_valid_in;
   logic state_move;
   logic rsp_valid_ff, rsp_valid_in;

   // Ramp state.
   logic [blp_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                        up_ff, up_in;

   // Counters.
   logic [COUNT_WIDTH-1:0]    pwm_count;
   logic [COUNT_WIDTH-1:0]    dwell_count;
   blp_pkg::count_status_type pwm_status;
   blp_pkg::count_status_type dwell_status;

   // Result stage.
   logic [blp_pkg::THRESH_W-1:0]  threshold;
   logic                          lit;
   logic [blp_pkg::LED_COUNT-1:0] led_mask_ff, led_mask_in;
   logic [blp_pkg::LEVEL_W-1:0]   level_now_ff;
   logic                          ramping_up_ff;

   // The state holds a finished beat until the result register can take it.
   assign state_move = state_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = state_valid_ff && !state_move;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_valid_in = state_valid_ff;
      if (req_accept) begin
         state_valid_in = 1'b1;
      end else if (state_move) begin
         state_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (state_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff   <= blp_pkg::PWM_PERIOD_RESET;
         duty_step_ff    <= blp_pkg::DUTY_STEP_RESET;
         top_level_ff    <= blp_pkg::TOP_LEVEL_RESET;
         dwell_length_ff <= blp_pkg::DWELL_LENGTH_RESET;
         led_select_ff   <= blp_pkg::LED_SELECT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            blp_pkg::CSR_PWM_PERIOD:   pwm_period_ff   <= csr_wdata;
            blp_pkg::CSR_DUTY_STEP:    duty_step_ff    <= csr_wdata;
            blp_pkg::CSR_TOP_LEVEL:    top_level_ff    <= csr_wdata[blp_pkg::LEVEL_W-1:0];
            blp_pkg::CSR_DWELL_LENGTH: dwell_length_ff <= csr_wdata;
            blp_pkg::CSR_LED_SELECT:   led_select_ff   <= csr_wdata[blp_pkg::SELECT_W-1:0];
            default: ;
         endcase
      end
   end

   blp_wrap_counter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_pwm_counter (
      .clock  (clock),
      .reset  (reset),
      .tick   (req_accept && req_fast_tick),
      .limit  (pwm_period_ff),
      .count  (pwm_count),
      .status (pwm_status)
   );

   blp_wrap_counter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dwell_counter (
      .clock  (clock),
      .reset  (reset),
      .tick   (req_accept && req_slow_tick),
      .limit  (dwell_length_ff),
      .count  (dwell_count),
      .status (dwell_status)
   );

   // At the end of a dwell, step the level or flip direction at an extreme.
   always_comb begin
      level_in = level_ff;
      up_in    = up_ff;
      if (dwell_status.wrapped) begin
         if (up_ff) begin
            if (level_ff >= top_level_ff) begin
               up_in = 1'b0;
            end else begin
               level_in = level_ff + blp_pkg::LEVEL_W'(1);
            end
         end else begin
            if (level_ff == '0) begin
               up_in = 1'b1;
            end else begin
               level_in = level_ff - blp_pkg::LEVEL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= '0;
         up_ff          <= 1'b1;
         state_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         level_ff       <= level_in;
         up_ff          <= up_in;
         state_valid_ff <= state_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Duty compare: the LED is on while the PWM count is below the threshold.
   always_comb begin
      threshold   = blp_pkg::THRESH_W'(level_ff) * blp_pkg::THRESH_W'(duty_step_ff);
      lit         = CMP_W'(pwm_count) < CMP_W'(threshold);
      led_mask_in = lit ? (blp_pkg::LED_COUNT'(1) << led_select_ff) : '0;
   end

   // Result register, loaded when the finished beat moves out of the state.
   always_ff @(posedge clock) begin
      if (state_move) begin
         led_mask_ff   <= led_mask_in;
         level_now_ff  <= level_ff;
         ramping_up_ff <= up_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_mask   = led_mask_ff;
   assign rsp_level_now  = level_now_ff;
   assign rsp_ramping_up = ramping_up_ff;

   // The dwell count, the tick flags and the PWM wrap flag are not needed beyond the counters.
   logic unused_ok;
   assign unused_ok = ^{dwell_count, pwm_status.ticked, pwm_status.wrapped,
                        dwell_status.ticked};

endmodule

### hw/rtl/blp_wrap_counter.sv
// Tick counter that wraps to zero when its next value reaches a limit.
// Used for both the PWM counter and the dwell counter.
// Depends on blp_pkg for the limit width and the status struct.
module blp_wrap_counter #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tick,
   input  logic [blp_pkg::LIMIT_W-1:0]    limit,
   output logic [COUNT_WIDTH-1:0]         count,
   output blp_pkg::count_status_type      status
);

   localparam int unsigned CMP_W =
      (COUNT_WIDTH > blp_pkg::LIMIT_W) ? COUNT_WIDTH : blp_pkg::LIMIT_W;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] incr;
   logic                   at_limit;

   // Increment with natural wrap, then fold to zero at or past the limit.
   always_comb begin
      incr     = count_ff + COUNT_WIDTH'(1);
      at_limit = CMP_W'(incr) >= CMP_W'(limit);
      count_in = count_ff;
      if (tick) begin
         count_in = at_limit ? '0 : incr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count          = count_ff;
   assign status.ticked  = tick;
   assign status.wrapped = tick && (count_in == '0);

endmodule

### hw/rtl/blp_checker.sv
// Port-level checks for the breathing LED PWM block, bound to the top level.
// Depends on blp_pkg for field widths.
module blp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [blp_pkg::LED_COUNT-1:0]  rsp_led_mask,
   input logic [blp_pkg::LEVEL_W-1:0]    rsp_level_now,
   input logic                           rsp_ramping_up
);

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // At most one LED is driven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_led_mask))
      else $error("more than one LED driven");

   // Level zero means zero duty, so the LED is dark.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_level_now == '0) |-> (rsp_led_mask == '0))
      else $error("LED lit at brightness level zero");

   // Consecutive results differ by at most one brightness level.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid |->
         (rsp_level_now == $past(rsp_level_now)) ||
         (rsp_level_now == $past(rsp_level_now) + blp_pkg::LEVEL_W'(1)) ||
         (rsp_level_now == $past(rsp_level_now) - blp_pkg::LEVEL_W'(1)))
      else $error("brightness level jumped by more than one");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_mask) &&
         $stable(rsp_level_now) && $stable(rsp_ramping_up))
      else $error("stalled result beat changed");

endmodule

bind breathing_led_pwm blp_checker u_blp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_led_mask   (rsp_led_mask),
   .rsp_level_now  (rsp_level_now),
   .rsp_ramping_up (rsp_ramping_up)
);
